// ===== rtl/sbe_pkg.sv =====
// Package: shared sizes, opcodes, event codes and the result record of the executor.
`timescale 1ns / 1ps
package sbe_pkg;

   localparam int STACK_DEPTH    = 1024;
   localparam int VARIABLE_SLOTS = 256;

   localparam int STACK_AW = $clog2(STACK_DEPTH);
   localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
   localparam int VAR_AW   = (VARIABLE_SLOTS > 1) ? $clog2(VARIABLE_SLOTS) : 1;

   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
   localparam logic [31:0]        VAR_SLOTS_W = 32'(VARIABLE_SLOTS);

   localparam int OPCODE_W = 8;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 16;
   localparam int EVENT_W  = 3;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 16;
   localparam int VARS_W   = 9;
   localparam int STRS_W   = 16;

   localparam logic [OPCODE_W-1:0] OP_PUSH  = 8'd1;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 8'd2;
   localparam logic [OPCODE_W-1:0] OP_STORE = 8'd3;
   localparam logic [OPCODE_W-1:0] OP_ADD   = 8'd4;
   localparam logic [OPCODE_W-1:0] OP_SUB   = 8'd5;
   localparam logic [OPCODE_W-1:0] OP_PRINT = 8'd6;
   localparam logic [OPCODE_W-1:0] OP_PSTR  = 8'd7;
   localparam logic [OPCODE_W-1:0] OP_HALT  = 8'd9;

   localparam logic [EVENT_W-1:0] EV_INT     = 3'd0;
   localparam logic [EVENT_W-1:0] EV_STR     = 3'd1;
   localparam logic [EVENT_W-1:0] EV_NULLSTR = 3'd2;
   localparam logic [EVENT_W-1:0] EV_HALT    = 3'd3;
   localparam logic [EVENT_W-1:0] EV_UNDER   = 3'd4;
   localparam logic [EVENT_W-1:0] EV_UNKNOWN = 3'd5;
   localparam logic [EVENT_W-1:0] EV_OVER    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_VARS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRS = 8'd1;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } rsp_type;

endpackage

// ===== rtl/sbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module sbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/stack_bytecode_executor_core.sv =====
// Stack bytecode executor: one instruction per transfer, stack and variables held in RAMs.
// Results are registered: into the output register, or into the skid while the output is held.
// Throughput: one instruction per cycle while the skid is empty; the top three stack entries live
//   in registers and the stack RAM read of the fourth entry, issued on every pop, lands in time for the next one.
// Reset (synchronous): stack empty, variables read as zero, block running, position zero,
//   both configuration registers zero. The stack RAM itself is not cleared.
`timescale 1ns / 1ps
module stack_bytecode_executor_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sbe_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic signed [sbe_pkg::VALUE_W-1:0] req_operand,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sbe_pkg::EVENT_W-1:0]      rsp_event_res,
   output logic signed [sbe_pkg::VALUE_W-1:0] rsp_value,
   output logic [sbe_pkg::POS_W-1:0]        rsp_position,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration
   logic [sbe_pkg::VARS_W-1:0] vars_in_use_ff;
   logic [sbe_pkg::STRS_W-1:0] strs_in_use_ff;

   // stack: tos, nos and third cached, RAM holds everything below third
   logic [sbe_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic [sbe_pkg::VALUE_W-1:0] tos_ff, tos_in, nos_ff, nos_in, third_ff, third_in;
   logic                        tos_var_ff, tos_var_in;     // tos pending from variable RAM
   logic                        var_hit_ff, var_hit_in;     // that read is in range and written
   logic                        third_ram_ff, third_ram_in; // third pending from stack RAM
   logic                        stopped_ff, stopped_in;
   logic [sbe_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [sbe_pkg::VARIABLE_SLOTS-1:0] var_valid_ff;

   // result buffer: output register plus skid
   logic              out_v_ff, skid_v_ff;
   sbe_pkg::rsp_type  out_ff, skid_ff, new_rsp;
   logic              new_v;

   logic [sbe_pkg::VALUE_W-1:0] stk_rdata, var_rdata;
   logic [sbe_pkg::VALUE_W-1:0] tos_cur, third_cur, arg, limit;
   logic                        stk_we, stk_re, var_we, var_re, var_ok, accept;
   logic [sbe_pkg::STACK_AW-1:0] stk_waddr, stk_raddr;
   logic [sbe_pkg::VAR_AW-1:0]   var_addr;
   logic [sbe_pkg::DEPTH_W-1:0]  depth_m2, depth_m4;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_v_ff;
   assign accept    = req_valid && req_ready;

   assign arg      = req_operand;
   assign limit    = ({23'd0, vars_in_use_ff} < sbe_pkg::VAR_SLOTS_W) ?
                     {23'd0, vars_in_use_ff} : sbe_pkg::VAR_SLOTS_W;
   assign var_ok   = !arg[sbe_pkg::VALUE_W-1] && (arg < limit);
   assign var_addr = arg[sbe_pkg::VAR_AW-1:0];

   assign tos_cur   = tos_var_ff ? (var_hit_ff ? var_rdata : '0) : tos_ff;
   assign third_cur = third_ram_ff ? stk_rdata : third_ff;

   assign depth_m2  = depth_ff - sbe_pkg::DEPTH_W'(2);
   assign depth_m4  = depth_ff - sbe_pkg::DEPTH_W'(4);
   assign stk_waddr = depth_m2[sbe_pkg::STACK_AW-1:0];
   assign stk_raddr = depth_m4[sbe_pkg::STACK_AW-1:0];

   always_comb begin
      depth_in     = depth_ff;
      tos_in       = tos_ff;
      tos_var_in   = tos_var_ff;
      var_hit_in   = var_hit_ff;
      nos_in       = nos_ff;
      third_in     = third_ff;
      third_ram_in = third_ram_ff;
      stopped_in   = stopped_ff;
      pos_in       = pos_ff;
      stk_we       = 1'b0;
      stk_re       = 1'b0;
      var_we       = 1'b0;
      var_re       = 1'b0;
      new_v        = 1'b0;
      new_rsp.event_res = sbe_pkg::EV_UNKNOWN;
      new_rsp.value     = {24'd0, req_opcode};
      new_rsp.position  = pos_ff;

      if (accept && !stopped_ff) begin
         case (req_opcode)
            sbe_pkg::OP_PUSH, sbe_pkg::OP_LOAD: begin
               if (depth_ff >= sbe_pkg::DEPTH_FULL) begin
                  new_v             = 1'b1;
                  new_rsp.event_res = sbe_pkg::EV_OVER;
                  stopped_in        = 1'b1;
               end else begin
                  stk_we       = (depth_ff >= sbe_pkg::DEPTH_W'(2));
                  third_in     = nos_ff;
                  third_ram_in = 1'b0;
                  nos_in       = tos_cur;
                  if (req_opcode == sbe_pkg::OP_PUSH) begin
                     tos_in     = arg;
                     tos_var_in = 1'b0;
                  end else begin
                     var_re     = 1'b1;
                     tos_var_in = 1'b1;
                     var_hit_in = var_ok && var_valid_ff[var_addr];
                  end
                  depth_in = depth_ff + sbe_pkg::DEPTH_W'(1);
                  pos_in   = pos_ff + sbe_pkg::POS_W'(2);
               end
            end
            sbe_pkg::OP_STORE, sbe_pkg::OP_PRINT: begin
               if (depth_ff == '0) begin
                  new_v             = 1'b1;
                  new_rsp.event_res = sbe_pkg::EV_UNDER;
                  stopped_in        = 1'b1;
               end else begin
                  if (req_opcode == sbe_pkg::OP_STORE) begin
                     var_we = var_ok;
                     pos_in = pos_ff + sbe_pkg::POS_W'(2);
                  end else begin
                     new_v             = 1'b1;
                     new_rsp.event_res = sbe_pkg::EV_INT;
                     new_rsp.value     = tos_cur;
                     pos_in            = pos_ff + sbe_pkg::POS_W'(1);
                  end
                  tos_in       = nos_ff;
                  tos_var_in   = 1'b0;
                  nos_in       = third_cur;
                  stk_re       = 1'b1;
                  third_ram_in = 1'b1;
                  depth_in     = depth_ff - sbe_pkg::DEPTH_W'(1);
               end
            end
            sbe_pkg::OP_ADD, sbe_pkg::OP_SUB: begin
               if (depth_ff < sbe_pkg::DEPTH_W'(2)) begin
                  new_v             = 1'b1;
                  new_rsp.event_res = sbe_pkg::EV_UNDER;
                  stopped_in        = 1'b1;
               end else begin
                  tos_in       = (req_opcode == sbe_pkg::OP_ADD) ? nos_ff + tos_cur :
                                                                    nos_ff - tos_cur;
                  tos_var_in   = 1'b0;
                  nos_in       = third_cur;
                  stk_re       = 1'b1;
                  third_ram_in = 1'b1;
                  depth_in     = depth_ff - sbe_pkg::DEPTH_W'(1);
                  pos_in       = pos_ff + sbe_pkg::POS_W'(1);
               end
            end
            sbe_pkg::OP_PSTR: begin
               new_v         = 1'b1;
               new_rsp.value = arg;
               new_rsp.event_res = (!arg[sbe_pkg::VALUE_W-1] && (arg < {16'd0, strs_in_use_ff})) ?
                                   sbe_pkg::EV_STR : sbe_pkg::EV_NULLSTR;
               pos_in = pos_ff + sbe_pkg::POS_W'(2);
            end
            sbe_pkg::OP_HALT: begin
               new_v             = 1'b1;
               new_rsp.event_res = sbe_pkg::EV_HALT;
               stopped_in        = 1'b1;
            end
            default: begin
               new_v             = 1'b1;
               new_rsp.event_res = sbe_pkg::EV_UNKNOWN;
               stopped_in        = 1'b1;
            end
         endcase
      end
   end

   sbe_ram #(
      .WIDTH(sbe_pkg::VALUE_W),
      .DEPTH(sbe_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (stk_we),
      .wr_addr(stk_waddr),
      .wr_data(nos_ff),
      .rd_en  (stk_re),
      .rd_addr(stk_raddr),
      .rd_data(stk_rdata)
   );

   sbe_ram #(
      .WIDTH(sbe_pkg::VALUE_W),
      .DEPTH(sbe_pkg::VARIABLE_SLOTS)
   ) u_var_ram (
      .clock  (clock),
      .wr_en  (var_we),
      .wr_addr(var_addr),
      .wr_data(tos_cur),
      .rd_en  (var_re),
      .rd_addr(var_addr),
      .rd_data(var_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vars_in_use_ff <= '0;
         strs_in_use_ff <= '0;
         depth_ff       <= '0;
         tos_var_ff     <= 1'b0;
         var_hit_ff     <= 1'b0;
         third_ram_ff   <= 1'b0;
         stopped_ff     <= 1'b0;
         pos_ff         <= '0;
         var_valid_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sbe_pkg::CSR_VARS: vars_in_use_ff <= csr_wdata[sbe_pkg::VARS_W-1:0];
               sbe_pkg::CSR_STRS: strs_in_use_ff <= csr_wdata[sbe_pkg::STRS_W-1:0];
               default: ;
            endcase
         end
         depth_ff     <= depth_in;
         tos_var_ff   <= tos_var_in;
         var_hit_ff   <= var_hit_in;
         third_ram_ff <= third_ram_in;
         stopped_ff   <= stopped_in;
         pos_ff       <= pos_in;
         if (var_we) begin
            var_valid_ff[var_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tos_ff   <= tos_in;
      nos_ff   <= nos_in;
      third_ff <= third_in;
   end

   // result buffer: new results go to the output register, or to the skid if it is held
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ready) begin
         out_v_ff  <= skid_v_ff || new_v;
         skid_v_ff <= 1'b0;
      end else if (new_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ready) begin
         out_ff <= skid_v_ff ? skid_ff : new_rsp;
      end else if (new_v) begin
         skid_ff <= new_rsp;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_event_res = out_ff.event_res;
   assign rsp_value     = out_ff.value;
   assign rsp_position  = out_ff.position;

endmodule

// ===== sim/sbe_result_check.sv =====
// Result checker for the stack bytecode executor: tracks transfers, predicts events, compares.
`timescale 1ns / 1ps
module sbe_result_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [sbe_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [sbe_pkg::VALUE_W-1:0]    req_operand,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [sbe_pkg::EVENT_W-1:0]    rsp_event_res,
   input  logic [sbe_pkg::VALUE_W-1:0]    rsp_value,
   input  logic [sbe_pkg::POS_W-1:0]      rsp_position,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [sbe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbe_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             outstanding,
   output int                             results_checked
);
   import sbe_pkg::*;

   rsp_type            event_q[$];
   logic [VALUE_W-1:0] stack_mem [0:STACK_DEPTH-1];
   logic [VALUE_W-1:0] var_mem [0:VARIABLE_SLOTS-1];
   int unsigned        depth;
   logic               halted;
   logic [POS_W-1:0]   word_pos;
   logic [VARS_W-1:0]  vars_reg;
   logic [STRS_W-1:0]  strs_reg;
   int                 bad = 0;
   int                 seen = 0;

   function automatic void queue_event(input logic [EVENT_W-1:0] ev,
                                       input logic [VALUE_W-1:0] val);
      rsp_type r;
      r.event_res = ev;
      r.value     = val;
      r.position  = word_pos;
      event_q.push_back(r);
   endfunction

   function automatic void stop_with(input logic [EVENT_W-1:0] ev,
                                     input logic [OPCODE_W-1:0] op);
      halted = 1'b1;
      queue_event(ev, VALUE_W'(op));
   endfunction

   // one instruction against the predicted machine state
   function automatic void step_executor(input logic [OPCODE_W-1:0] op,
                                         input logic [VALUE_W-1:0] arg);
      logic [VALUE_W-1:0] lhs;
      logic [VALUE_W-1:0] rhs;
      int unsigned        lim;
      logic               idx_ok;
      if (halted)
         return;
      lim    = (int'(vars_reg) < VARIABLE_SLOTS) ? int'(vars_reg) : VARIABLE_SLOTS;
      idx_ok = !arg[VALUE_W-1] && (arg < lim);
      case (op)
         OP_PUSH, OP_LOAD: begin
            if (depth >= STACK_DEPTH) begin
               stop_with(EV_OVER, op);
            end else begin
               if (op == OP_PUSH)
                  stack_mem[depth] = arg;
               else
                  stack_mem[depth] = idx_ok ? var_mem[arg[VAR_AW-1:0]] : '0;
               depth++;
               word_pos += POS_W'(2);
            end
         end
         OP_STORE: begin
            if (depth == 0) begin
               stop_with(EV_UNDER, op);
            end else begin
               depth--;
               if (idx_ok)
                  var_mem[arg[VAR_AW-1:0]] = stack_mem[depth];
               word_pos += POS_W'(2);
            end
         end
         OP_ADD, OP_SUB: begin
            if (depth < 2) begin
               stop_with(EV_UNDER, op);
            end else begin
               rhs = stack_mem[depth-1];
               lhs = stack_mem[depth-2];
               depth--;
               stack_mem[depth-1] = (op == OP_ADD) ? lhs + rhs : lhs - rhs;
               word_pos += POS_W'(1);
            end
         end
         OP_PRINT: begin
            if (depth == 0) begin
               stop_with(EV_UNDER, op);
            end else begin
               depth--;
               queue_event(EV_INT, stack_mem[depth]);
               word_pos += POS_W'(1);
            end
         end
         OP_PSTR: begin
            if (!arg[VALUE_W-1] && arg < strs_reg)
               queue_event(EV_STR, arg);
            else
               queue_event(EV_NULLSTR, arg);
            word_pos += POS_W'(2);
         end
         OP_HALT: stop_with(EV_HALT, op);
         default: stop_with(EV_UNKNOWN, op);
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         depth    = 0;
         halted   = 1'b0;
         word_pos = '0;
         vars_reg = '0;
         strs_reg = '0;
         for (int i = 0; i < VARIABLE_SLOTS; i++)
            var_mem[i] = '0;
         event_q.delete();
      end else begin
         // older result first: it cannot belong to an instruction of this edge
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (event_q.size() == 0) begin
               bad++;
               if (bad <= 10)
                  $display("[%0t] unexpected result: event %0d value %h position %0d",
                           $time, rsp_event_res, rsp_value, rsp_position);
            end else begin
               want = event_q.pop_front();
               if (rsp_event_res !== want.event_res || rsp_value !== want.value ||
                   rsp_position !== want.position) begin
                  bad++;
                  if (bad <= 10)
                     $display({"[%0t] result %0d wrong: expected event %0d value %h ",
                               "position %0d, got event %0d value %h position %0d"},
                              $time, seen, want.event_res, want.value, want.position,
                              rsp_event_res, rsp_value, rsp_position);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VARS)
               vars_reg = csr_wdata[VARS_W-1:0];
            else if (csr_index == CSR_STRS)
               strs_reg = csr_wdata[STRS_W-1:0];
         end
         if (req_valid && req_ready)
            step_executor(req_opcode, req_operand);
      end
      mismatches      <= bad;
      outstanding     <= event_q.size();
      results_checked <= seen;
   end

endmodule

// ===== sim/stack_bytecode_executor_core_tb.sv =====
// Testbench top for the stack bytecode executor: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps
module stack_bytecode_executor_core_tb;
   import sbe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int PHASE_ITEMS    = 150;
   localparam int STACK_SOFT_CAP = 200;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_ZERO  = 8'd0;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_EIGHT = 8'd8;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [OPCODE_W-1:0]        req_opcode;
   logic signed [VALUE_W-1:0]  req_operand;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [EVENT_W-1:0]         rsp_event_res;
   logic signed [VALUE_W-1:0]  rsp_value;
   logic [POS_W-1:0]           rsp_position;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   int              mismatches;
   int              outstanding;
   int              results_checked;
   bit              calm;
   bit              squeeze;
   bit              block_stopped;
   int              stack_now;
   int              stack_peak;
   int              instr_sent;
   int              ignored_sent;
   int              reg_writes;
   int              vars_cur;
   int              strs_cur;
   longint unsigned words_sent;
   string           end_kind;

   stack_bytecode_executor_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_operand   (req_operand),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_value     (rsp_value),
      .rsp_position  (rsp_position),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   sbe_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_value       (rsp_value),
      .rsp_position    (rsp_position),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, one long hold-off when asked
   initial begin
      bit squeezed_once;
      squeezed_once = 1'b0;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze && !squeezed_once) begin
            squeezed_once = 1'b1;
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, outstanding);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [VALUE_W-1:0] edgy_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_var_slot();
      int lim;
      lim = (vars_cur > VARIABLE_SLOTS) ? VARIABLE_SLOTS : vars_cur;
      case ($urandom_range(0, 9))
         0:       return edgy_word();
         1:       return 32'(lim + $urandom_range(0, 3));
         2:       return 32'(lim - 1);
         default: return (lim == 0) ? 32'($urandom_range(0, 255))
                                    : 32'($urandom_range(0, lim - 1));
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] string_index();
      case ($urandom_range(0, 9))
         0:       return edgy_word();
         1:       return 32'(strs_cur);
         2:       return 32'(strs_cur - 1);
         3:       return 32'h0000_FFFF;
         default: return 32'($urandom_range(0, strs_cur + 4));
      endcase
   endfunction

   // valid stays up between back-to-back transfers; only a gap lowers it
   task automatic issue(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] arg);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_operand <= arg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (block_stopped) begin
         ignored_sent++;
      end else begin
         instr_sent++;
         case (op)
            OP_PUSH, OP_LOAD: begin
               stack_now++;
               words_sent += 2;
            end
            OP_STORE: begin
               stack_now--;
               words_sent += 2;
            end
            OP_ADD, OP_SUB, OP_PRINT: begin
               stack_now--;
               words_sent += 1;
            end
            OP_PSTR: words_sent += 2;
            default: ;
         endcase
         if (stack_now > stack_peak && stack_now <= STACK_DEPTH)
            stack_peak = stack_now;
      end
   endtask

   task automatic issue_op(input logic [OPCODE_W-1:0] op);
      case (op)
         OP_PUSH:           issue(op, edgy_word());
         OP_LOAD, OP_STORE: issue(op, pick_var_slot());
         OP_PSTR:           issue(op, string_index());
         default:           issue(op, $urandom());
      endcase
   endtask

   task automatic random_instr();
      int                  roll;
      logic [OPCODE_W-1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < 25)      op = OP_PUSH;
      else if (roll < 40) op = OP_LOAD;
      else if (roll < 52) op = OP_STORE;
      else if (roll < 62) op = OP_ADD;
      else if (roll < 72) op = OP_SUB;
      else if (roll < 87) op = OP_PRINT;
      else                op = OP_PSTR;
      // keep the program well formed so the block keeps running
      if ((op == OP_ADD || op == OP_SUB) && stack_now < 2)
         op = OP_PUSH;
      if ((op == OP_STORE || op == OP_PRINT) && stack_now < 1)
         op = OP_LOAD;
      if ((op == OP_PUSH || op == OP_LOAD) && stack_now >= STACK_SOFT_CAP)
         op = OP_ADD;
      issue_op(op);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_VARS)
         vars_cur = data[VARS_W-1:0];
      else if (idx == CSR_STRS)
         strs_cur = data[STRS_W-1:0];
      reg_writes++;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] vars_word,
                            input logic [CSR_DATA_W-1:0] strs_word, input bit stray);
      if ($urandom_range(0, 1)) begin
         write_reg(CSR_VARS, vars_word);
         write_reg(CSR_STRS, strs_word);
      end else begin
         write_reg(CSR_STRS, strs_word);
         write_reg(CSR_VARS, vars_word);
      end
      if (stray)
         write_reg(CSR_STRS + CSR_IDX_W'($urandom_range(1, 254)), CSR_DATA_W'($urandom()));
      csr_valid <= 1'b0;
   endtask

   // drain: no transfer in flight, all results back, pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int                  phase;
      int                  keep;
      logic [OPCODE_W-1:0] op;
      req_valid     = 1'b0;
      req_opcode    = '0;
      req_operand   = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      reset         = 1'b1;
      calm          = 1'b0;
      squeeze       = 1'b0;
      block_stopped = 1'b0;
      stack_now     = 0;
      stack_peak    = 0;
      instr_sent    = 0;
      ignored_sent  = 0;
      reg_writes    = 0;
      vars_cur      = 0;
      strs_cur      = 0;
      words_sent    = 0;
      end_kind      = "";
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no variables and no strings in use
      issue(OP_PUSH, 32'd5);
      issue(OP_LOAD, 32'd0);
      issue(OP_ADD, 32'hFFFF_FFFF);
      issue(OP_STORE, 32'd0);
      issue(OP_LOAD, 32'd0);
      issue(OP_PRINT, 32'h8000_0000);
      issue(OP_PSTR, 32'd0);
      settle();

      configure(16'd256, 16'd10, 1'b0);
      // wrap on add and sub
      issue(OP_PUSH, 32'h7FFF_FFFF);
      issue(OP_PUSH, 32'd1);
      issue(OP_ADD, 32'd0);
      issue(OP_PRINT, 32'd0);
      issue(OP_PUSH, 32'h8000_0000);
      issue(OP_PUSH, 32'd1);
      issue(OP_SUB, 32'hFFFF_FFFF);
      // last slot, then out-of-range and negative indices
      issue(OP_STORE, 32'd255);
      issue(OP_LOAD, 32'd255);
      issue(OP_PRINT, 32'd0);
      issue(OP_PUSH, 32'hFFFF_FFFF);
      issue(OP_STORE, 32'hFFFF_FFFF);
      issue(OP_LOAD, 32'd256);
      issue(OP_LOAD, 32'hFFFF_FFFB);
      issue(OP_SUB, 32'd0);
      issue(OP_PRINT, 32'd0);
      issue(OP_PSTR, 32'd9);
      issue(OP_PSTR, 32'hFFFF_FFFF);
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       configure(16'hFFFF, 16'hFFFF, 1'b0);
            1:       configure(16'd1, 16'd0, 1'b0);
            2:       configure(16'd0, 16'd1, 1'b1);
            3:       configure(16'($urandom_range(0, 256)), 16'($urandom_range(0, 300)), 1'b0);
            4:       configure(16'd128, 16'($urandom()), 1'b0);
            default: configure(16'd256, 16'hFFFE, 1'b0);
         endcase
         if (phase == 5)
            calm = 1'b1;
         if (phase == 3) begin
            // results pile up behind a stalled receiver
            squeeze = 1'b1;
            repeat (40) issue_op(OP_PSTR);
         end
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 39) == 0)
               repeat ($urandom_range(1, 40))
                  issue_op($urandom_range(0, 1) ? OP_PUSH : OP_LOAD);
            else
               random_instr();
         end
         settle();
      end

      case ($urandom_range(0, 3))
         0: begin
            end_kind = "halt";
            issue(OP_HALT, $urandom());
         end
         1: begin
            end_kind = "unknown opcode";
            case ($urandom_range(0, 2))
               0:       op = OP_UNUSED_ZERO;
               1:       op = OP_UNUSED_EIGHT;
               default: op = OPCODE_W'($urandom_range(int'(OP_HALT) + 1, 255));
            endcase
            issue(op, $urandom());
         end
         2: begin
            end_kind = "stack underflow";
            keep = $urandom_range(0, 1);
            while (stack_now > keep)
               issue_op(OP_PRINT);
            if (keep == 1)
               op = $urandom_range(0, 1) ? OP_ADD : OP_SUB;
            else
               case ($urandom_range(0, 3))
                  0:       op = OP_STORE;
                  1:       op = OP_PRINT;
                  2:       op = OP_ADD;
                  default: op = OP_SUB;
               endcase
            issue_op(op);
         end
         default: begin
            end_kind = "stack overflow";
            while (stack_now < STACK_DEPTH)
               issue_op($urandom_range(0, 1) ? OP_PUSH : OP_LOAD);
            issue_op($urandom_range(0, 1) ? OP_PUSH : OP_LOAD);
         end
      endcase
      block_stopped = 1'b1;
      // a stopped block must swallow everything
      repeat (24) issue(OPCODE_W'($urandom_range(0, 255)), $urandom());

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("run: %0d instructions executed, %0d sent after the stop, %0d results checked",
               instr_sent, ignored_sent, results_checked);
      $display("run: %0d register writes, stack peaked at %0d, %0d code words, ended on %s",
               reg_writes, stack_peak, words_sent, end_kind);
      if (mismatches == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sbe_pkg.sv
rtl/sbe_ram.sv
rtl/stack_bytecode_executor_core.sv
sim/sbe_result_check.sv
sim/stack_bytecode_executor_core_tb.sv
